/* hw/rtl/thp_pkg.sv */
// Shared constants, widths and types for the hidden-path planner.
`timescale 1ns / 1ps

package thp_pkg;

    localparam int EVALS_PER_REP = 256;
    localparam int REPETITIONS   = 17;
    localparam int TREE_LEVELS   = 13;

    localparam int LEAF_COUNT  = EVALS_PER_REP * REPETITIONS;
    localparam int FULL_LEVEL  = 1 << TREE_LEVELS;
    localparam int TWO_N       = 2 * LEAF_COUNT;
    localparam int DEEP_LEAVES = (TWO_N > FULL_LEVEL) ? (TWO_N - FULL_LEVEL) : 0;
    localparam int STORE_DEPTH = TREE_LEVELS + 1;

    localparam int LEAF_W  = 13;
    localparam int NODE_W  = 14;
    localparam int HID_W   = 8;
    localparam int SIB_W   = 10;
    localparam int LIMIT_W = 10;
    localparam int SEEN_W  = 5;
    localparam int ADD_W   = $clog2(STORE_DEPTH + 1);

    localparam logic [SEEN_W-1:0]  SEEN_MAX    = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

    typedef struct packed {
        logic look;
        logic clr;
        logic shift;
    } t_cell_ctrl;

endpackage

/* hw/rtl/thp_cell.sv */
// One depth of the path store, with its match chain link and emission token.
`timescale 1ns / 1ps

module thp_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  thp_pkg::t_cell_ctrl        i_ctrl,
    input  logic [thp_pkg::NODE_W-1:0] i_anc,
    input  logic                       i_active,
    input  logic                       i_seen_below,
    output logic                       o_seen,
    input  logic                       i_new_above,
    output logic                       o_new,
    input  logic                       i_tok_above,
    output logic                       o_tok,
    output logic [thp_pkg::NODE_W-1:0] o_sel
);
    import thp_pkg::*;

    logic [NODE_W-1:0] r_store;
    logic              r_tok;
    logic [NODE_W-1:0] w_eff;
    logic [NODE_W-1:0] n_store;

    assign w_eff   = i_ctrl.clr ? '0 : r_store;
    assign o_seen  = (i_active && (w_eff == i_anc)) || i_seen_below;
    assign o_new   = i_active && !o_seen;
    assign n_store = o_new ? i_anc : w_eff;
    assign o_tok   = r_tok;
    assign o_sel   = r_tok ? r_store : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_tok   <= 1'b0;
        end else if (i_ctrl.look) begin
            r_store <= n_store;
            r_tok   <= o_new && !i_new_above;
        end else if (i_ctrl.shift) begin
            r_tok   <= i_tok_above;
        end
    end

endmodule

/* hw/rtl/tree_hidden_path_planner.sv */
// Top level of the hidden-path planner: leaf mapping, counts and result register.
`timescale 1ns / 1ps
// A leaf is taken in idle; the lookup state follows, then emit registers results.
// A leaf that hides k nodes gives k results; one that hides none gives one result
// with no valid node. Results come one per cycle while the output is not stalled.
// The emission token steps one store cell per cycle while the output slot is free.
// A new leaf is taken while the final result still waits in the output register.
// Synchronous reset clears the path store, the counts and sets the limit to 1023.

module tree_hidden_path_planner (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [thp_pkg::LIMIT_W-1:0]        i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [thp_pkg::LEAF_W-1:0]         i_leaf,
    input  logic                               i_first_leaf,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [thp_pkg::NODE_W-1:0]         o_hidden_node,
    output logic                               o_node_valid,
    output logic [thp_pkg::HID_W-1:0]          o_hidden_count,
    output logic signed [thp_pkg::SIB_W-1:0]   o_sibling_count,
    output logic                               o_over_limit,
    output logic                               o_last_result
);
    import thp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EMIT} t_state;

    t_state              r_state;
    logic [LIMIT_W-1:0]  r_limit;
    logic [NODE_W-1:0]   r_node;
    logic                r_deep;
    logic                r_leaf_ok;
    logic                r_first;
    logic                r_null;
    logic [HID_W-1:0]    r_hid;
    logic [SIB_W-1:0]    r_sib;
    logic [SEEN_W-1:0]   r_seen;
    logic                r_ovl;
    logic                r_out_valid;
    logic [NODE_W-1:0]   r_out_node;
    logic                r_out_nvalid;
    logic [HID_W-1:0]    r_out_hid;
    logic [SIB_W-1:0]    r_out_sib;
    logic                r_out_ovl;
    logic                r_out_last;

    logic [31:0]         w_leaf32;
    logic [31:0]         w_node32;
    logic                w_deep;
    logic                w_accept;
    logic                w_slot_free;
    logic                w_last;
    t_cell_ctrl          w_ctrl;
    logic [STORE_DEPTH:0]   w_seen_chain;
    logic [STORE_DEPTH-1:0] w_new;
    logic [STORE_DEPTH-1:0] w_tok;
    logic [STORE_DEPTH-1:0] w_active;
    logic [NODE_W-1:0]      w_anc [STORE_DEPTH];
    logic [NODE_W-1:0]      w_sel [STORE_DEPTH];
    logic [NODE_W-1:0]      w_emit_node;
    logic [ADD_W-1:0]       w_added;
    logic [HID_W-1:0]       w_base_hid;
    logic [SIB_W-1:0]       w_base_sib;
    logic [SEEN_W-1:0]      w_base_seen;
    logic [HID_W-1:0]       n_hid;
    logic [SIB_W-1:0]       n_sib;
    logic [SEEN_W-1:0]      n_seen;
    logic                   n_ovl;

    assign w_leaf32 = {{(32 - LEAF_W){1'b0}}, i_leaf};
    assign w_deep   = w_leaf32 < 32'(DEEP_LEAVES);
    assign w_node32 = w_deep ? (32'(FULL_LEVEL) + w_leaf32)
                             : (32'(FULL_LEVEL) + w_leaf32 - 32'(LEAF_COUNT));

    assign o_stall     = (r_state != S_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign w_slot_free = !r_out_valid || !i_stall;

    assign w_ctrl.look  = (r_state == S_LOOK);
    assign w_ctrl.clr   = r_first;
    assign w_ctrl.shift = (r_state == S_EMIT) && w_slot_free;

    assign w_seen_chain[STORE_DEPTH] = 1'b0;

    genvar d;
    generate
        for (d = 0; d < STORE_DEPTH; d++) begin : g_cell
            if (d == TREE_LEVELS) begin : g_deepest
                assign w_anc[d]    = r_node;
                assign w_active[d] = r_leaf_ok && r_deep;
            end else begin : g_upper
                assign w_anc[d]    = r_deep ? (r_node >> (TREE_LEVELS - d))
                                            : (r_node >> (TREE_LEVELS - 1 - d));
                assign w_active[d] = r_leaf_ok;
            end

            logic w_new_above;
            logic w_tok_above;
            if (d == 0) begin : g_top
                assign w_new_above = 1'b0;
                assign w_tok_above = 1'b0;
            end else begin : g_inner
                assign w_new_above = w_new[d-1];
                assign w_tok_above = w_tok[d-1];
            end

            thp_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_anc        (w_anc[d]),
                .i_active     (w_active[d]),
                .i_seen_below (w_seen_chain[d+1]),
                .o_seen       (w_seen_chain[d]),
                .i_new_above  (w_new_above),
                .o_new        (w_new[d]),
                .i_tok_above  (w_tok_above),
                .o_tok        (w_tok[d]),
                .o_sel        (w_sel[d])
            );
        end
    endgenerate

    always_comb begin
        w_emit_node = '0;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            w_emit_node = w_emit_node | w_sel[k];
        end
    end

    assign w_added     = ADD_W'($countones(w_new));
    assign w_base_hid  = r_first ? '0 : r_hid;
    assign w_base_sib  = r_first ? '0 : r_sib;
    assign w_base_seen = r_first ? '0 : r_seen;

    always_comb begin
        n_hid  = w_base_hid;
        n_sib  = w_base_sib;
        n_seen = w_base_seen;
        if (r_leaf_ok) begin
            n_hid  = w_base_hid + HID_W'(w_added);
            n_sib  = w_base_sib + SIB_W'(w_added) - SIB_W'(1)
                     - SIB_W'(w_base_seen != '0);
            n_seen = (w_base_seen == SEEN_MAX) ? w_base_seen
                                               : w_base_seen + SEEN_W'(1);
        end
        n_ovl = n_sib[SIB_W-1] || (n_sib > r_limit);
    end

    assign w_last = r_null || (r_deep ? w_tok[TREE_LEVELS] : w_tok[TREE_LEVELS-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_hid       <= '0;
            r_sib       <= '0;
            r_seen      <= '0;
            r_first     <= 1'b0;
            r_leaf_ok   <= 1'b0;
            r_null      <= 1'b0;
            r_ovl       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (r_out_valid && !i_stall && !((r_state == S_EMIT) && w_slot_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_node    <= w_node32[NODE_W-1:0];
                        r_deep    <= w_deep;
                        r_leaf_ok <= w_leaf32 < 32'(LEAF_COUNT);
                        r_first   <= i_first_leaf;
                        r_state   <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_hid   <= n_hid;
                    r_sib   <= n_sib;
                    r_seen  <= n_seen;
                    r_ovl   <= n_ovl;
                    r_null  <= (w_added == '0);
                    r_first <= 1'b0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_node   <= r_null ? '0 : w_emit_node;
                        r_out_nvalid <= !r_null;
                        r_out_hid    <= r_hid;
                        r_out_sib    <= r_sib;
                        r_out_ovl    <= r_ovl;
                        r_out_last   <= w_last;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hidden_node   = r_out_node;
    assign o_node_valid    = r_out_nvalid;
    assign o_hidden_count  = r_out_hid;
    assign o_sibling_count = $signed(r_out_sib);
    assign o_over_limit    = r_out_ovl;
    assign o_last_result   = r_out_last;

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOOK))
        else $error("accepted leaf did not enter the lookup cycle");

    a_token_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_null) |-> $onehot(w_tok))
        else $error("emission token is not one-hot while nodes are emitted");

    a_null_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_null) |-> (w_tok == '0))
        else $error("emission token present for a leaf that hid no node");

    a_node_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_node_valid) |-> (o_hidden_node != '0))
        else $error("valid hidden node carries index zero");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_slot_free) |=> o_valid)
        else $error("emission step left the result register empty");

endmodule
